// ===== rtl/core/frc_pkg.sv =====
// Package with screen geometry, opcodes and shared types of the fill engine.
package frc_pkg;
  localparam int ScreenWidth  = 172;
  localparam int ScreenHeight = 320;
  localparam int Depth        = ScreenWidth * ScreenHeight;
  localparam int AddrW        = $clog2(Depth);
  localparam int ColorW       = 16;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_RECT   = 2'd1,
    OP_CIRCLE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic signed [11:0] span_w;
    logic signed [11:0] span_h;
    logic [9:0]  radius;
    logic [15:0] pixel_color;
  } cmd_t;

  // Request to and answer from the square root unit.
  typedef struct packed {
    logic        start;
    logic [19:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [10:0] root;
  } sqrt_rsp_t;
endpackage

// ===== rtl/core/frc_if.sv =====
// Valid/ready channel interfaces for commands and read results.
interface frc_cmd_if;
  logic          valid;
  logic          ready;
  frc_pkg::cmd_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface frc_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_pixel;
  modport source (output valid, output read_pixel, input ready);
  modport sink   (input valid, input read_pixel, output ready);
endinterface

// ===== rtl/core/framebuffer_rect_circle_fill_core.sv =====
// Top level of the rectangle and circle fill engine.
// The engine takes one command at a time and is not ready until it is finished. Drawing writes
// one pixel per cycle through the single frame RAM port, after the S_BOX setup state for a clear
// or rectangle; a circle waits, before each row, for the iterative square root and then writes
// its clipped span. A pixel read goes through S_READ and S_RWAIT to the registered RAM output,
// then the result waits in an output register until taken.
// The frame store has no reset; read only pixels that were drawn.
module framebuffer_rect_circle_fill_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  frc_cmd_if.sink     cmd_i,
  frc_rsp_if.source   rsp_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_BOX, S_PAINT, S_ROW, S_ROOT, S_READ, S_RWAIT, S_OUT
  } state_e;

  localparam int W = frc_pkg::ScreenWidth;
  localparam int H = frc_pkg::ScreenHeight;

  state_e             state_q;
  frc_pkg::cmd_t      cmd_q;
  logic signed [13:0] col_q, col_end_q, row_q, row_end_q;
  logic signed [11:0] dy_q;
  logic [frc_pkg::AddrW-1:0] addr_q;
  logic               we_q, circ_q;
  logic [15:0]        rdata;
  frc_pkg::sqrt_req_t sreq;
  frc_pkg::sqrt_rsp_t srsp;
  logic [19:0]        rr, dd;

  logic signed [13:0] bx0, bx1, by0, by1;
  logic signed [13:0] cx0, cx1, cy;
  logic signed [13:0] sx0, sx1;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = (state_q == S_OUT);

  always_comb begin
    bx0 = 14'(cmd_q.pos_x);
    by0 = 14'(cmd_q.pos_y);
    bx1 = bx0 + 14'(cmd_q.span_w);
    by1 = by0 + 14'(cmd_q.span_h);
    if (cmd_q.opcode == frc_pkg::OP_CLEAR) begin
      bx0 = '0; by0 = '0; bx1 = 14'(W); by1 = 14'(H);
    end
    if (bx0 < 0) bx0 = '0;
    if (by0 < 0) by0 = '0;
    if (bx1 > 14'(W)) bx1 = 14'(W);
    if (by1 > 14'(H)) by1 = 14'(H);
  end

  always_comb begin
    cx0 = 14'(cmd_q.pos_x) - 14'(srsp.root);
    cx1 = 14'(cmd_q.pos_x) + 14'(srsp.root) + 14'sd1;
    cy  = 14'(cmd_q.pos_y) + 14'(dy_q);
    sx0 = (cx0 < 0) ? 14'sd0 : cx0;
    sx1 = (cx1 > 14'(W)) ? 14'(W) : cx1;
  end

  // The r*r and dy*dy terms are narrow; one multiplier each feeds the root unit.
  assign rr = 20'(cmd_q.radius) * 20'(cmd_q.radius);
  assign dd = 20'($unsigned(dy_q < 0 ? -dy_q : dy_q)) * 20'($unsigned(dy_q < 0 ? -dy_q : dy_q));
  assign sreq.start = (state_q == S_ROW);
  assign sreq.value = rr - dd;

  frc_sqrt u_sqrt (.clk_i, .rst_ni, .req_i(sreq), .rsp_o(srsp));

  frc_ram #(.Width(frc_pkg::ColorW), .Depth(frc_pkg::Depth)) u_ram (
    .clk_i, .we_i(we_q), .addr_i(addr_q), .wdata_i(cmd_q.pixel_color), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      we_q    <= 1'b0;
      circ_q  <= 1'b0;
      cmd_q <= '0; col_q <= '0; col_end_q <= '0; row_q <= '0; row_end_q <= '0;
      dy_q <= '0; addr_q <= '0; rsp_o.read_pixel <= '0;
    end else begin
      we_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_i.valid) begin
            cmd_q <= cmd_i.payload;
            case (frc_pkg::op_e'(cmd_i.payload.opcode))
              frc_pkg::OP_CLEAR: state_q <= S_BOX;
              frc_pkg::OP_RECT: state_q <= (cmd_i.payload.span_w > 0 &&
                                           cmd_i.payload.span_h > 0) ? S_BOX : S_IDLE;
              frc_pkg::OP_CIRCLE: begin
                dy_q    <= -12'($signed({2'b00, cmd_i.payload.radius}));
                circ_q  <= 1'b1;
                state_q <= S_ROW;
              end
              default: begin
                // The read address goes out right away so that the RAM output is ready
                // by the capture in S_RWAIT.
                addr_q  <= frc_pkg::AddrW'(14'(cmd_i.payload.pos_y) * 14'(W) +
                                           14'(cmd_i.payload.pos_x));
                state_q <= S_READ;
              end
            endcase
          end
        end
        S_BOX: begin
          circ_q <= 1'b0;
          col_q <= bx0; col_end_q <= bx1; row_q <= by0; row_end_q <= by1;
          state_q <= (bx0 < bx1 && by0 < by1) ? S_PAINT : S_IDLE;
        end
        S_PAINT: begin
          addr_q <= frc_pkg::AddrW'(row_q * 14'(W) + col_q);
          we_q   <= 1'b1;
          if (col_q + 14'sd1 < col_end_q) begin
            col_q <= col_q + 14'sd1;
          end else if (!circ_q && row_q + 14'sd1 < row_end_q) begin
            col_q <= bx0;
            row_q <= row_q + 14'sd1;
          end else if (circ_q && dy_q < 12'($signed({2'b00, cmd_q.radius}))) begin
            dy_q    <= dy_q + 12'sd1;
            state_q <= S_ROW;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_ROW: state_q <= S_ROOT;
        S_ROOT: begin
          if (srsp.done) begin
            col_q <= sx0; col_end_q <= sx1; row_q <= cy;
            if (cy >= 0 && cy < 14'(H) && sx0 < sx1) begin
              state_q <= S_PAINT;
            end else if (dy_q < 12'($signed({2'b00, cmd_q.radius}))) begin
              dy_q    <= dy_q + 12'sd1;
              state_q <= S_ROW;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_READ: begin
          state_q <= S_RWAIT;
        end
        S_RWAIT: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (rsp_o.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_RWAIT) begin
        rsp_o.read_pixel <= (cmd_q.pos_x >= 0 && cmd_q.pos_x < 12'(W) &&
                             cmd_q.pos_y >= 0 && cmd_q.pos_y < 12'(H)) ? rdata : '0;
      end
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !cmd_i.ready) else $error("ready during output");
  a_write_paint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_q |-> $past(state_q == S_PAINT)) else $error("stray write");
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_q |-> (addr_q < frc_pkg::AddrW'(frc_pkg::Depth))) else $error("address range");
endmodule

// ===== rtl/core/frc_ram.sv =====
// Generic single-port RAM with registered read.
module frc_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/core/frc_sqrt.sv =====
// Iterative rounded integer square root; it takes a new value only when idle.
module frc_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  frc_pkg::sqrt_req_t   req_i,
  output frc_pkg::sqrt_rsp_t   rsp_o
);
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_ROUND} state_e;
  state_e      state_q;
  logic [21:0] rem_q;
  logic [21:0] res_q;
  logic [21:0] bit_q;
  logic [21:0] trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rsp_o   <= '0;
      rem_q   <= '0;
      res_q   <= '0;
      bit_q   <= '0;
    end else begin
      rsp_o.done <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            rem_q   <= {2'b00, req_i.value};
            res_q   <= '0;
            bit_q   <= 22'd1 << 20;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (rem_q >= trial) begin
            rem_q <= rem_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          // The root rounds up when the remainder exceeds the root itself.
          rsp_o.root <= res_q[10:0] + 11'(rem_q > res_q);
          rsp_o.done <= 1'b1;
          state_q    <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !rsp_o.done) else $error("sqrt done held");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |=> (state_q == S_IDLE)) else $error("sqrt round");
  a_done_from_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> $past(state_q == S_ROUND)) else $error("sqrt stray done");
endmodule

// ===== tb/tb_framebuffer_rect_circle_fill_core.sv =====
// Self-checking testbench of the framebuffer rectangle and circle fill engine.
module tb_framebuffer_rect_circle_fill_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the frame store; it predicts the pixel that every read returns.
  class pixel_scoreboard;
    logic [15:0] frame [frc_pkg::Depth];
    logic [15:0] pending_pixels[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void paint(int x0, int x1, int y0, int y1, logic [15:0] color);
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > frc_pkg::ScreenWidth) x1 = frc_pkg::ScreenWidth;
      if (y1 > frc_pkg::ScreenHeight) y1 = frc_pkg::ScreenHeight;
      for (int row = y0; row < y1; row++)
        for (int col = x0; col < x1; col++)
          frame[row * frc_pkg::ScreenWidth + col] = color;
    endfunction

    // Square root rounded to nearest: floor root, then up when n >= r*r + r + 1.
    function int round_root(int n);
      int root;
      root = 0;
      for (int b = 10; b >= 0; b--)
        if ((root + (1 << b)) * (root + (1 << b)) <= n) root += (1 << b);
      if (n - root * root > root) root++;
      return root;
    endfunction

    function void note_cmd(frc_pkg::cmd_t c);
      int px, py, w, h, r, dx;
      px = $signed(c.pos_x);
      py = $signed(c.pos_y);
      w = $signed(c.span_w);
      h = $signed(c.span_h);
      r = c.radius;
      case (frc_pkg::op_e'(c.opcode))
        frc_pkg::OP_CLEAR:
          paint(0, frc_pkg::ScreenWidth, 0, frc_pkg::ScreenHeight, c.pixel_color);
        frc_pkg::OP_RECT: if (w > 0 && h > 0) paint(px, px + w, py, py + h, c.pixel_color);
        frc_pkg::OP_CIRCLE: begin
          for (int dy = -r; dy <= r; dy++) begin
            dx = round_root(r * r - dy * dy);
            paint(px - dx, px + dx + 1, py + dy, py + dy + 1, c.pixel_color);
          end
        end
        default: begin
          if (px >= 0 && px < frc_pkg::ScreenWidth && py >= 0 && py < frc_pkg::ScreenHeight)
            pending_pixels.push_back(frame[py * frc_pkg::ScreenWidth + px]);
          else
            pending_pixels.push_back(16'h0000);
        end
      endcase
    endfunction

    task check_pixel(logic [15:0] got);
      logic [15:0] want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected read result %h", got));
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) report($sformatf("read_pixel %h, expected %h", got, want));
      end
    endtask
  endclass

  logic clk, rst_n;
  frc_cmd_if cmd_if ();
  frc_rsp_if rsp_if ();
  pixel_scoreboard sb;
  bit calm;
  int hold_cnt;

  framebuffer_rect_circle_fill_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Caller is at a rising edge; returns at the edge where the transfer happens.
  task send_cmd(frc_pkg::cmd_t c);
    cmd_if.valid <= 1'b1;
    cmd_if.payload <= c;
    do @(posedge clk); while (!cmd_if.ready);
    sb.note_cmd(c);
  endtask

  task sender_gap();
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 5);
      cmd_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function frc_pkg::cmd_t mk(frc_pkg::op_e op, int x, int y, int w, int h, int r,
                             logic [15:0] color);
    frc_pkg::cmd_t c;
    c.opcode = op;
    c.pos_x = x[11:0];
    c.pos_y = y[11:0];
    c.span_w = w[11:0];
    c.span_h = h[11:0];
    c.radius = r[9:0];
    c.pixel_color = color;
    return c;
  endfunction

  function frc_pkg::cmd_t random_cmd();
    frc_pkg::cmd_t c;
    int pick;
    c = frc_pkg::cmd_t'(76'({$urandom, $urandom, $urandom}));
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      // Full-range noise; the opcode stays a drawing or a read.
      c.opcode = 2'($urandom_range(1, 3));
    end else if (pick < 42) begin
      c.opcode = frc_pkg::OP_READ;
      c.pos_x = 12'($urandom_range(0, 9) == 0 ? $urandom :
                    $urandom_range(0, frc_pkg::ScreenWidth - 1));
      c.pos_y = 12'($urandom_range(0, 9) == 0 ? $urandom :
                    $urandom_range(0, frc_pkg::ScreenHeight - 1));
    end else if (pick < 72) begin
      c.opcode = frc_pkg::OP_RECT;
      c.pos_x = 12'($signed($urandom_range(0, 191)) - 10);
      c.pos_y = 12'($signed($urandom_range(0, 339)) - 10);
      c.span_w = 12'($signed($urandom_range(0, 23)) - 3);
      c.span_h = 12'($signed($urandom_range(0, 23)) - 3);
    end else begin
      c.opcode = frc_pkg::OP_CIRCLE;
      c.pos_x = 12'($signed($urandom_range(0, 191)) - 10);
      c.pos_y = 12'($signed($urandom_range(0, 339)) - 10);
      c.radius = 10'($urandom_range(0, 12));
    end
    return c;
  endfunction

  initial begin
    frc_pkg::cmd_t d[$];
    sb = new();
    rst_n <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.payload <= '0;
    calm = 1'b0;
    hold_cnt = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The clear comes first so that no read ever touches an unwritten pixel.
    d.push_back(mk(frc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 16'hA5A5));
    d.push_back(mk(frc_pkg::OP_READ, 0, 0, 0, 0, 0, 16'h0));
    d.push_back(mk(frc_pkg::OP_READ, frc_pkg::ScreenWidth - 1, frc_pkg::ScreenHeight - 1,
                   0, 0, 0, 16'h0));
    d.push_back(mk(frc_pkg::OP_READ, -1, 0, 0, 0, 0, 16'h0));
    d.push_back(mk(frc_pkg::OP_READ, frc_pkg::ScreenWidth, 0, 0, 0, 0, 16'h0));
    d.push_back(mk(frc_pkg::OP_READ, 0, frc_pkg::ScreenHeight, 0, 0, 0, 16'h0));
    d.push_back(mk(frc_pkg::OP_READ, -2048, 2047, 0, 0, 0, 16'h0));
    d.push_back(mk(frc_pkg::OP_RECT, 5, 5, 0, 10, 0, 16'h1234));
    d.push_back(mk(frc_pkg::OP_RECT, 5, 5, 10, -2048, 0, 16'h1234));
    d.push_back(mk(frc_pkg::OP_READ, 5, 5, 0, 0, 0, 16'h0));
    d.push_back(mk(frc_pkg::OP_RECT, -5, -5, 10, 10, 0, 16'hFFFF));
    d.push_back(mk(frc_pkg::OP_READ, 4, 4, 0, 0, 0, 16'h0));
    d.push_back(mk(frc_pkg::OP_RECT, 168, 316, 2047, 2047, 0, 16'h0F0F));
    d.push_back(mk(frc_pkg::OP_READ, frc_pkg::ScreenWidth - 1, frc_pkg::ScreenHeight - 1,
                   0, 0, 0, 16'h0));
    d.push_back(mk(frc_pkg::OP_RECT, -2048, -2048, 2047, 2047, 0, 16'h0000));
    d.push_back(mk(frc_pkg::OP_CIRCLE, 50, 60, 0, 0, 0, 16'hBEEF));
    d.push_back(mk(frc_pkg::OP_READ, 50, 60, 0, 0, 0, 16'h0));
    d.push_back(mk(frc_pkg::OP_READ, 51, 60, 0, 0, 0, 16'h0));
    d.push_back(mk(frc_pkg::OP_CIRCLE, 2, 318, 0, 0, 7, 16'h7E0F));
    d.push_back(mk(frc_pkg::OP_READ, 0, 319, 0, 0, 0, 16'h0));
    d.push_back(mk(frc_pkg::OP_CIRCLE, 86, 160, 0, 0, 1023, 16'hF800));
    d.push_back(mk(frc_pkg::OP_READ, 171, 0, 0, 0, 0, 16'h0));
    d.push_back(mk(frc_pkg::OP_CIRCLE, 2047, -2048, 0, 0, 1, 16'h001F));
    d.push_back(mk(frc_pkg::OP_READ, 86, 160, 0, 0, 0, 16'h0));
    foreach (d[i]) begin
      send_cmd(d[i]);
      sender_gap();
    end

    for (int i = 0; i < 1150; i++) begin
      if (i == 1000) calm = 1'b1;
      if (i == 400 || i == 800)
        send_cmd(mk(frc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 16'($urandom)));
      if (i == 300) begin
        // Long receiver stall while reads keep coming, so the input backs up.
        hold_cnt = 3000;
        for (int k = 0; k < 8; k++)
          send_cmd(mk(frc_pkg::OP_READ, $urandom_range(0, frc_pkg::ScreenWidth - 1),
                       $urandom_range(0, frc_pkg::ScreenHeight - 1), 0, 0, 0, 16'h0));
      end
      if (i == 600) begin
        cmd_if.valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge clk);
      end
      send_cmd(random_cmd());
      sender_gap();
    end
    cmd_if.valid <= 1'b0;

    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int burst;
    bit rdy;
    burst = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) sb.check_pixel(rsp_if.read_pixel);
      if (hold_cnt > 0) begin
        hold_cnt--;
        rdy = 1'b0;
      end else if (burst > 0) begin
        burst--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      rsp_if.ready <= rdy;
    end
  end
endmodule
